/* hdl/assert_macros.svh */
// Assertion macros shared by the parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define RTTI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// A condition in one cycle that implies a condition in the next cycle.
`define RTTI_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/rtti_pkg.sv */
// Shared constants, codes and beat types of the radix text parser.
package rtti_pkg;

    // Alphabet and value sizes.
    localparam int MAX_SYMBOLS = 16;
    localparam int SYM_W       = 8;
    localparam int DIGIT_W     = $clog2(MAX_SYMBOLS);
    localparam int COUNT_W     = 5;
    localparam int VALUE_WIDTH = 32;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // Width of the accumulator times the radix before truncation.
    localparam int PROD_W      = VALUE_WIDTH + COUNT_W;

    // Queue between the classifier and the accumulator.
    localparam int QUEUE_AW      = 1;
    localparam int QUEUE_DEPTH   = 2 ** QUEUE_AW;
    localparam int QUEUE_COUNT_W = QUEUE_AW + 1;
    localparam logic [QUEUE_COUNT_W-1:0] QUEUE_FULL_COUNT = QUEUE_COUNT_W'(QUEUE_DEPTH);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALPHABET_LOW  = 2'd0,
        CFG_ALPHABET_HIGH = 2'd1,
        CFG_SYMBOL_COUNT  = 2'd2
    } t_cfg_index;

    // Character codes used by the prefix scanner and the alphabet check.
    localparam logic [SYM_W-1:0] CHAR_TAB   = 8'h09;
    localparam logic [SYM_W-1:0] CHAR_LF    = 8'h0A;
    localparam logic [SYM_W-1:0] CHAR_VT    = 8'h0B;
    localparam logic [SYM_W-1:0] CHAR_FF    = 8'h0C;
    localparam logic [SYM_W-1:0] CHAR_CR    = 8'h0D;
    localparam logic [SYM_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [SYM_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [SYM_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [SYM_W-1:0] PRINT_LO   = 8'd32;
    localparam logic [SYM_W-1:0] PRINT_HI   = 8'd126;

    // Input beat: one text byte.
    typedef struct packed {
        logic [SYM_W-1:0] char_code;
        logic             end_of_text;
    } t_in_beat;

    // Output beat: one parsed number.
    typedef struct packed {
        logic signed [VALUE_WIDTH-1:0] number;
        logic                          alphabet_ok;
    } t_out_beat;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic               prefix;
        logic               minus;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               ok;
    } t_class;

endpackage

/* hdl/rtti_front.sv */
// Front end: configuration registers, alphabet check and byte classification.
module rtti_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rtti_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                              i_in_valid,
    input  rtti_pkg::t_in_beat                i_in_data,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output rtti_pkg::t_class                  o_cls,
    output logic [rtti_pkg::COUNT_W-1:0]      o_symbol_count
);

    logic [rtti_pkg::CFG_W-1:0]   r_alphabet_low;
    logic [rtti_pkg::CFG_W-1:0]   r_alphabet_high;
    logic [rtti_pkg::COUNT_W-1:0] r_symbol_count;

    logic [2*rtti_pkg::CFG_W-1:0] w_symbols;
    logic [rtti_pkg::SYM_W-1:0]   w_sym  [rtti_pkg::MAX_SYMBOLS];
    logic                         w_used [rtti_pkg::MAX_SYMBOLS];
    logic                         w_ok;
    logic [rtti_pkg::DIGIT_W-1:0] w_digit;
    logic [rtti_pkg::SYM_W-1:0]   w_c;

    // Configuration registers, written one at a time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alphabet_low  <= '0;
            r_alphabet_high <= '0;
            r_symbol_count  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rtti_pkg::CFG_ALPHABET_LOW:  r_alphabet_low  <= i_cfg_data;
                rtti_pkg::CFG_ALPHABET_HIGH: r_alphabet_high <= i_cfg_data;
                rtti_pkg::CFG_SYMBOL_COUNT:
                    r_symbol_count <= i_cfg_data[rtti_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Split the alphabet into symbols and mark the ones in use.
    assign w_symbols = {r_alphabet_high, r_alphabet_low};
    always_comb begin
        for (int k = 0; k < rtti_pkg::MAX_SYMBOLS; k++) begin
            w_sym[k]  = w_symbols[k*rtti_pkg::SYM_W +: rtti_pkg::SYM_W];
            w_used[k] = rtti_pkg::COUNT_W'(k) < r_symbol_count;
        end
    end

    // Alphabet check: count in range, printable symbols, no signs, no duplicates.
    always_comb begin
        w_ok = (r_symbol_count >= rtti_pkg::COUNT_W'(2)) &&
               (r_symbol_count <= rtti_pkg::COUNT_W'(rtti_pkg::MAX_SYMBOLS));
        for (int i = 0; i < rtti_pkg::MAX_SYMBOLS; i++) begin
            if (w_used[i] && ((w_sym[i] == rtti_pkg::CHAR_PLUS) ||
                              (w_sym[i] == rtti_pkg::CHAR_MINUS) ||
                              (w_sym[i] < rtti_pkg::PRINT_LO) ||
                              (w_sym[i] > rtti_pkg::PRINT_HI))) begin
                w_ok = 1'b0;
            end
            for (int j = i + 1; j < rtti_pkg::MAX_SYMBOLS; j++) begin
                if (w_used[i] && w_used[j] && (w_sym[i] == w_sym[j])) begin
                    w_ok = 1'b0;
                end
            end
        end
    end

    // Digit lookup: the lowest matching symbol wins, no match gives zero.
    assign w_c = i_in_data.char_code;
    always_comb begin
        w_digit = '0;
        for (int i = rtti_pkg::MAX_SYMBOLS - 1; i >= 0; i--) begin
            if (w_used[i] && (w_sym[i] == w_c)) begin
                w_digit = rtti_pkg::DIGIT_W'(i);
            end
        end
    end

    // Classified beat toward the queue.
    always_comb begin
        o_cls.prefix = (w_c == rtti_pkg::CHAR_SPACE) || (w_c == rtti_pkg::CHAR_TAB) ||
                       (w_c == rtti_pkg::CHAR_LF) || (w_c == rtti_pkg::CHAR_CR) ||
                       (w_c == rtti_pkg::CHAR_VT) || (w_c == rtti_pkg::CHAR_FF) ||
                       (w_c == rtti_pkg::CHAR_PLUS) || (w_c == rtti_pkg::CHAR_MINUS);
        o_cls.minus  = (w_c == rtti_pkg::CHAR_MINUS);
        o_cls.digit  = w_digit;
        o_cls.last   = i_in_data.end_of_text;
        o_cls.ok     = w_ok;
    end

    assign o_push         = i_in_valid && !i_queue_full;
    assign o_symbol_count = r_symbol_count;

endmodule

/* hdl/rtti_queue.sv */
// Two-entry queue of classified bytes between the front and the back.
`include "assert_macros.svh"

module rtti_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rtti_pkg::t_class i_push_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_not_empty,
    output rtti_pkg::t_class o_head
);

    rtti_pkg::t_class                   r_mem [rtti_pkg::QUEUE_DEPTH];
    logic [rtti_pkg::QUEUE_AW-1:0]      r_wr_ptr;
    logic [rtti_pkg::QUEUE_AW-1:0]      r_rd_ptr;
    logic [rtti_pkg::QUEUE_COUNT_W-1:0] r_count;
    logic [rtti_pkg::QUEUE_COUNT_W-1:0] n_count;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill count.
    assign n_count = r_count + rtti_pkg::QUEUE_COUNT_W'(i_push)
                   - rtti_pkg::QUEUE_COUNT_W'(i_pop);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    assign o_full      = (r_count == rtti_pkg::QUEUE_FULL_COUNT);
    assign o_not_empty = (r_count != '0);
    assign o_head      = r_mem[r_rd_ptr];

    `RTTI_ASSERT(a_count_bound, r_count <= rtti_pkg::QUEUE_FULL_COUNT, "queue overfilled")
    `RTTI_ASSERT(a_no_pop_empty, !(i_pop && (r_count == '0)), "pop from empty queue")
    `RTTI_ASSERT_NEXT(a_push_grows, i_push && !i_pop, r_count == $past(r_count) + 1'b1, "no growth")

endmodule

/* hdl/rtti_back.sv */
// Back end: sign tracking, Horner accumulation and the output register.
`include "assert_macros.svh"

module rtti_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  rtti_pkg::t_class              i_head,
    input  logic [rtti_pkg::COUNT_W-1:0]  i_symbol_count,
    output logic                          o_pop,
    output logic                          o_out_valid,
    output rtti_pkg::t_out_beat           o_out_data,
    input  logic                          i_out_stall
);

    logic                                r_in_digits;
    logic                                r_negative;
    logic [rtti_pkg::VALUE_WIDTH-1:0]    r_acc;
    logic                                r_out_valid;
    rtti_pkg::t_out_beat                 r_out;

    logic                                n_in_digits;
    logic                                n_negative;
    logic [rtti_pkg::VALUE_WIDTH-1:0]    n_acc;
    logic [rtti_pkg::PROD_W-1:0]         w_prod;
    logic [rtti_pkg::VALUE_WIDTH-1:0]    w_value;
    logic                                w_take_last;
    logic                                w_bad_nonzero;

    // Take a byte unless it is final and the output beat cannot leave.
    assign o_pop = i_head_valid && (!i_head.last || !r_out_valid || !i_out_stall);

    // One step: skip leading prefix bytes, else multiply and add the digit.
    always_comb begin
        w_prod      = r_acc * i_symbol_count;
        n_in_digits = r_in_digits;
        n_negative  = r_negative;
        n_acc       = r_acc;
        if (!r_in_digits && i_head.prefix) begin
            n_negative = r_negative ^ i_head.minus;
        end else begin
            n_in_digits = 1'b1;
            n_acc = w_prod[rtti_pkg::VALUE_WIDTH-1:0] +
                    rtti_pkg::VALUE_WIDTH'(i_head.digit);
        end
        w_value = n_negative ? ('0 - n_acc) : n_acc;
    end

    // Parse state, cleared after the final byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_digits <= 1'b0;
            r_negative  <= 1'b0;
            r_acc       <= '0;
        end else if (o_pop) begin
            if (i_head.last) begin
                r_in_digits <= 1'b0;
                r_negative  <= 1'b0;
                r_acc       <= '0;
            end else begin
                r_in_digits <= n_in_digits;
                r_negative  <= n_negative;
                r_acc       <= n_acc;
            end
        end
    end

    // Output register: loaded on a final byte, freed when the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && i_head.last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.last) begin
            r_out.number      <= i_head.ok ? w_value : '0;
            r_out.alphabet_ok <= i_head.ok;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Terms for the checks below.
    assign w_take_last   = o_pop && i_head.last;
    assign w_bad_nonzero = !r_out.alphabet_ok && (r_out.number != '0);

    `RTTI_ASSERT(a_no_overwrite, !(w_take_last && r_out_valid && i_out_stall), "result lost")
    `RTTI_ASSERT(a_bad_alpha_zero, !(r_out_valid && w_bad_nonzero), "invalid alphabet, nonzero")

endmodule

/* hdl/radix_text_to_integer_parser.sv */
// Top level of the radix text parser: front, queue and back wired together.
//
// Parses a byte stream into a signed 32-bit integer using a configured alphabet
// of up to 16 symbols whose length is the radix. One byte is accepted per clock
// cycle unless o_in_stall is high, with no gaps between strings. The front
// classifies each byte in the cycle it is accepted and writes it into a
// two-entry queue; the back takes one byte per cycle from that queue while it
// is not empty and the byte is not a final byte held by a pending result, and
// does one 32-by-5-bit multiply-add per byte. The result beat for a string is
// presented from the cycle after the back takes its final byte. A pending
// result beat does not block later bytes; only the final byte of the next
// string waits for it to be taken. Configuration writes take effect at the
// next edge and must be made only while no bytes are in flight.
module radix_text_to_integer_parser (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rtti_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtti_pkg::CFG_W-1:0]      i_cfg_data,
    input  logic                            i_in_valid,
    input  rtti_pkg::t_in_beat              i_in_data,
    output logic                            o_in_stall,
    output logic                            o_out_valid,
    output rtti_pkg::t_out_beat             o_out_data,
    input  logic                            i_out_stall
);

    logic                          w_push;
    logic                          w_full;
    logic                          w_not_empty;
    logic                          w_pop;
    rtti_pkg::t_class              w_push_cls;
    rtti_pkg::t_class              w_head;
    logic [rtti_pkg::COUNT_W-1:0]  w_symbol_count;

    // Classifier and configuration registers.
    rtti_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_data      (i_in_data),
        .i_queue_full   (w_full),
        .o_push         (w_push),
        .o_cls          (w_push_cls),
        .o_symbol_count (w_symbol_count)
    );

    // Decoupling queue.
    rtti_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_cls),
        .i_pop       (w_pop),
        .o_full      (w_full),
        .o_not_empty (w_not_empty),
        .o_head      (w_head)
    );

    // Accumulator and output register.
    rtti_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head_valid   (w_not_empty),
        .i_head         (w_head),
        .i_symbol_count (w_symbol_count),
        .o_pop          (w_pop),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data),
        .i_out_stall    (i_out_stall)
    );

    assign o_in_stall = w_full;

endmodule
